FILE: hdl/dhc_pkg.sv
`timescale 1ns / 1ps

package dhc_pkg;

    // field and datapath widths
    localparam int DbWidth    = 20;
    localparam int ChanWidth  = 8;
    localparam int QuoWidth   = 13;
    localparam int NumWidth   = 32;
    localparam int RemWidth   = 20;
    localparam int IdxWidth   = 5;
    localparam int RgbWidth   = 3 * ChanWidth;
    localparam int AddrWidth  = 3;
    localparam int DataWidth  = 32;

    // scale factors of the two ramps
    localparam int GrayScale   = 255;
    localparam int ColourScale = 18 * 256;

    // floor register limits and reset
    localparam logic signed [DbWidth-1:0] FloorMax   = -20'sd256;
    localparam logic signed [DbWidth-1:0] FloorReset = -20'sd46080;
    localparam logic                      GrayReset  = 1'b0;

    typedef logic signed [DbWidth-1:0] db_t;
    typedef logic [ChanWidth-1:0]      chan_t;

    typedef enum logic
    {
        REG_FLOOR_DB,
        REG_GRAY_MODE
    } reg_index_t;

    typedef enum logic [1:0]
    {
        CLS_RAMP,
        CLS_WHITE,
        CLS_BLACK
    } level_class_t;

    typedef struct packed
    {
        logic         gray;
        level_class_t cls;
    } dhc_ctrl_t;

    // partial remainder, numerator bits shifting out / quotient bits shifting in
    typedef struct packed
    {
        logic [RemWidth-1:0] rem;
        logic [QuoWidth-1:0] bits;
        logic [RemWidth-1:0] nf;
    } div_word_t;

    // heat map, 0 dB first, floor last; packed as {red, green, blue}
    function automatic logic [RgbWidth-1:0] heat_rgb(input logic [IdxWidth-1:0] idx);
        logic [RgbWidth-1:0] rgb;
        case (idx)
            5'd0:    rgb = {8'd255, 8'd255, 8'd255};
            5'd1:    rgb = {8'd240, 8'd254, 8'd216};
            5'd2:    rgb = {8'd242, 8'd251, 8'd185};
            5'd3:    rgb = {8'd253, 8'd245, 8'd143};
            5'd4:    rgb = {8'd253, 8'd200, 8'd102};
            5'd5:    rgb = {8'd252, 8'd144, 8'd66};
            5'd6:    rgb = {8'd252, 8'd75,  8'd32};
            5'd7:    rgb = {8'd237, 8'd28,  8'd41};
            5'd8:    rgb = {8'd214, 8'd3,   8'd64};
            5'd9:    rgb = {8'd183, 8'd3,   8'd101};
            5'd10:   rgb = {8'd157, 8'd3,   8'd122};
            5'd11:   rgb = {8'd122, 8'd3,   8'd126};
            5'd12:   rgb = {8'd80,  8'd2,   8'd110};
            5'd13:   rgb = {8'd45,  8'd2,   8'd89};
            5'd14:   rgb = {8'd19,  8'd2,   8'd70};
            5'd15:   rgb = {8'd1,   8'd3,   8'd53};
            5'd16:   rgb = {8'd1,   8'd3,   8'd37};
            5'd17:   rgb = {8'd1,   8'd2,   8'd19};
            default: rgb = {8'd0,   8'd0,   8'd0};
        endcase
        return rgb;
    endfunction

endpackage

FILE: hdl/dhc_front.sv
`timescale 1ns / 1ps

module dhc_front
    import dhc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  db_t       db_value,
    input  db_t       floor_db,
    input  logic      gray_mode,
    output logic      out_valid,
    input  logic      out_stall,
    output dhc_ctrl_t out_ctrl,
    output div_word_t out_word
);

    logic      valid_reg;
    dhc_ctrl_t ctrl_reg;
    dhc_ctrl_t ctrl_next;
    div_word_t word_reg;
    div_word_t word_next;
    db_t       floor_eff;
    logic [RemWidth-1:0] nf;
    logic [RemWidth-1:0] nv;
    logic [NumWidth-1:0] num;
    logic                load;

    assign in_stall = valid_reg && out_stall;
    assign load     = !in_stall;

    always_comb
    begin
        // floors above the limit behave as the limit
        floor_eff = (floor_db > FloorMax) ? FloorMax : floor_db;
        nf        = ~floor_eff + 20'd1;
        nv        = ~db_value + 20'd1;

        ctrl_next.gray = gray_mode;
        if (!db_value[DbWidth-1])
            ctrl_next.cls = CLS_WHITE;
        else if (db_value <= floor_eff)
            ctrl_next.cls = CLS_BLACK;
        else
            ctrl_next.cls = CLS_RAMP;

        // numerator below scale * nf, so quotient fits QuoWidth bits
        if (ctrl_next.cls != CLS_RAMP)
            num = '0;
        else if (gray_mode)
            num = NumWidth'({12'd0, nv} * 32'(GrayScale));
        else
            num = NumWidth'({12'd0, nv} * 32'(ColourScale));

        word_next.rem  = {1'b0, num[NumWidth-1:QuoWidth]};
        word_next.bits = num[QuoWidth-1:0];
        word_next.nf   = nf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            ctrl_reg <= ctrl_next;
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_word  = word_reg;

endmodule

FILE: hdl/dhc_div_step.sv
`timescale 1ns / 1ps

module dhc_div_step
    import dhc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  dhc_ctrl_t in_ctrl,
    input  div_word_t in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output dhc_ctrl_t out_ctrl,
    output div_word_t out_word
);

    logic      valid_reg;
    dhc_ctrl_t ctrl_reg;
    div_word_t word_reg;
    div_word_t word_next;
    logic [RemWidth:0] shifted;
    logic [RemWidth:0] diff;
    logic              ge;
    logic              load;

    assign in_stall = valid_reg && out_stall;
    assign load     = !in_stall;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    always_comb
    begin
        shifted        = {in_word.rem, in_word.bits[QuoWidth-1]};
        diff           = shifted - {1'b0, in_word.nf};
        ge             = shifted >= {1'b0, in_word.nf};
        word_next.rem  = ge ? diff[RemWidth-1:0] : shifted[RemWidth-1:0];
        word_next.bits = {in_word.bits[QuoWidth-2:0], ge};
        word_next.nf   = in_word.nf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            ctrl_reg <= in_ctrl;
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_word  = word_reg;

`ifndef NO_ASSERTIONS
    // partial remainder stays below the divisor for ramp levels
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && ctrl_reg.cls == CLS_RAMP |-> word_reg.rem < word_reg.nf)
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: hdl/dhc_blend.sv
`timescale 1ns / 1ps

module dhc_blend
    import dhc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dhc_ctrl_t           in_ctrl,
    input  logic [QuoWidth-1:0] in_quo,
    output logic                out_valid,
    input  logic                out_stall,
    output chan_t               red,
    output chan_t               green,
    output chan_t               blue
);

    // stage 1: table lookup
    logic                s1_valid_reg;
    dhc_ctrl_t           s1_ctrl_reg;
    chan_t               s1_frac_reg;
    chan_t               s1_gray_reg;
    logic [RgbWidth-1:0] s1_lo_reg;
    logic [RgbWidth-1:0] s1_hi_reg;
    logic                s1_stall;
    logic                s1_load;
    logic [IdxWidth-1:0] idx;

    // stage 2: blend, round, output register
    logic                out_valid_reg;
    logic                mono_reg;
    logic [RgbWidth-1:0] rgb_reg;
    logic [RgbWidth-1:0] rgb_next;
    logic                s2_load;
    logic [8:0]          w_lo;
    logic [16:0]         acc;
    chan_t               a_ch;
    chan_t               b_ch;
    chan_t               q_ch;
    chan_t               r_ch;
    logic                round_up;

    assign s1_stall = out_valid_reg && out_stall;
    assign s2_load  = !s1_stall;
    assign in_stall = s1_valid_reg && s1_stall;
    assign s1_load  = !in_stall;
    assign idx      = in_quo[QuoWidth-1:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= in_valid;
            if (s2_load)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_ctrl_reg <= in_ctrl;
            s1_frac_reg <= in_quo[7:0];
            s1_gray_reg <= 8'd255 - in_quo[7:0];
            s1_lo_reg   <= heat_rgb(idx);
            s1_hi_reg   <= heat_rgb(idx + 5'd1);
        end
    end

    always_comb
    begin
        rgb_next = '0;
        w_lo     = 9'd256 - {1'b0, s1_frac_reg};
        acc      = '0;
        a_ch     = '0;
        b_ch     = '0;
        q_ch     = '0;
        r_ch     = '0;
        round_up = 1'b0;
        case (s1_ctrl_reg.cls)
            CLS_WHITE: rgb_next = {RgbWidth{1'b1}};
            CLS_BLACK: rgb_next = '0;
            CLS_RAMP:
            begin
                if (s1_ctrl_reg.gray)
                    rgb_next = {3{s1_gray_reg}};
                else
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        a_ch     = s1_lo_reg[c*ChanWidth +: ChanWidth];
                        b_ch     = s1_hi_reg[c*ChanWidth +: ChanWidth];
                        acc      = ({8'd0, w_lo} * {9'd0, a_ch})
                                 + ({9'd0, s1_frac_reg} * {9'd0, b_ch});
                        q_ch     = acc[15:8];
                        r_ch     = acc[7:0];
                        // round to nearest, ties to even
                        round_up = (r_ch > 8'd128) || (r_ch == 8'd128 && q_ch[0]);
                        rgb_next[c*ChanWidth +: ChanWidth] =
                            (round_up && q_ch != 8'hFF) ? q_ch + 8'd1 : q_ch;
                    end
                end
            end
            default: rgb_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            rgb_reg  <= rgb_next;
            mono_reg <= s1_ctrl_reg.gray || s1_ctrl_reg.cls != CLS_RAMP;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = rgb_reg[2*ChanWidth +: ChanWidth];
    assign green     = rgb_reg[ChanWidth +: ChanWidth];
    assign blue      = rgb_reg[0 +: ChanWidth];

`ifndef NO_ASSERTIONS
    a_colour_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ctrl.cls == CLS_RAMP && !in_ctrl.gray
        |-> in_quo < 13'(ColourScale))
        else $error("colour position beyond last table step");

    a_gray_quotient_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ctrl.cls == CLS_RAMP && in_ctrl.gray
        |-> in_quo < 13'(GrayScale))
        else $error("gray quotient out of range");

    a_mono_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && mono_reg |-> red == green && green == blue)
        else $error("gray, white or black pixel with unequal channels");
`endif

endmodule

FILE: hdl/decibel_to_heatmap_colour.sv
`timescale 1ns / 1ps

// Maps one spectrum level (signed, 1/256 dB) to one RGB pixel. In color mode
// the range from floor_db up to 0 dB is laid over an 18-step heat table and
// the two nearest entries are blended with an 8-bit fraction, rounded to
// nearest with ties to even; 0 dB and above is white and anything at or
// below the floor is black. In gray mode the same range maps to gray 1..255
// and the floor and below to black. The block takes one request per clock
// unless a stalled output has backed up the pipeline. Its stages, in order,
// are one for the floor clamp, class decode and scaling, the pipelined
// restoring divider (one quotient bit per stage, set by the 13-bit table
// position), one for the table lookup and one for the blend into the output
// register. Every stage has its own valid bit and only holds when the stage
// after it is full and stalled, so bubbles are squeezed out and a stalled
// output still lets new requests in. Registers: floor_db at byte address 0
// (values above -256 act as -256, reset -180 dB), gray_mode at byte address
// 4 (reset 0); write them only while no request is in flight.

module decibel_to_heatmap_colour
    import dhc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // level in
    input  logic                 in_valid,
    output logic                 in_stall,
    input  db_t                  db_value,
    // pixel out
    output logic                 out_valid,
    input  logic                 out_stall,
    output chan_t                red,
    output chan_t                green,
    output chan_t                blue,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready
);

    db_t        floor_db_reg;
    logic       gray_mode_reg;
    logic       cfg_write;
    reg_index_t cfg_index;

    // front stage to divider and through the divider chain
    logic      st_valid [0:QuoWidth];
    logic      st_stall [0:QuoWidth];
    dhc_ctrl_t st_ctrl  [0:QuoWidth];
    div_word_t st_word  [0:QuoWidth];

    // ---------------------------------------------------------------
    // register port, no wait states; address bit 2 selects the register
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_db_reg  <= FloorReset;
            gray_mode_reg <= GrayReset;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FLOOR_DB:  floor_db_reg  <= pwdata[DbWidth-1:0];
                REG_GRAY_MODE: gray_mode_reg <= pwdata[0];
                default:       floor_db_reg  <= floor_db_reg;
            endcase
        end
    end

    // floor reads back sign extended
    always_comb
    begin
        case (cfg_index)
            REG_FLOOR_DB:  prdata = DataWidth'(floor_db_reg);
            REG_GRAY_MODE: prdata = {{(DataWidth-1){1'b0}}, gray_mode_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // clamp, classify and scale the level
    // ---------------------------------------------------------------
    dhc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .db_value  (db_value),
        .floor_db  (floor_db_reg),
        .gray_mode (gray_mode_reg),
        .out_valid (st_valid[0]),
        .out_stall (st_stall[0]),
        .out_ctrl  (st_ctrl[0]),
        .out_word  (st_word[0])
    );

    // ---------------------------------------------------------------
    // divider: one quotient bit per stage, msb first
    // ---------------------------------------------------------------
    for (genvar i = 0; i < QuoWidth; i++)
    begin : g_div
        dhc_div_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[i]),
            .in_stall  (st_stall[i]),
            .in_ctrl   (st_ctrl[i]),
            .in_word   (st_word[i]),
            .out_valid (st_valid[i+1]),
            .out_stall (st_stall[i+1]),
            .out_ctrl  (st_ctrl[i+1]),
            .out_word  (st_word[i+1])
        );
    end

    // ---------------------------------------------------------------
    // table lookup, blend and output register
    // ---------------------------------------------------------------
    dhc_blend u_blend
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid[QuoWidth]),
        .in_stall  (st_stall[QuoWidth]),
        .in_ctrl   (st_ctrl[QuoWidth]),
        .in_quo    (st_word[QuoWidth].bits),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

`ifndef NO_ASSERTIONS
    // input only backs up when a finished pixel is held at the output
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");
`endif

endmodule

FILE: bench/tb_decibel_to_heatmap_colour.sv
`timescale 1ns / 1ps

module tb_decibel_to_heatmap_colour;
    import dhc_pkg::*;

    localparam int HeatSteps     = 18;
    localparam int LevelsPerRun  = 150;
    localparam int RandomPhases  = 10;
    localparam int DrainCycles   = 24;
    localparam int LongHold      = 300;
    localparam int WatchdogLimit = 2000;
    localparam int MaxReported   = 60;

    // heat map from 0 dB down to the floor, {red, green, blue}
    localparam logic [RgbWidth-1:0] HeatTable [HeatSteps+1] = '{
        {8'd255, 8'd255, 8'd255}, {8'd240, 8'd254, 8'd216}, {8'd242, 8'd251, 8'd185},
        {8'd253, 8'd245, 8'd143}, {8'd253, 8'd200, 8'd102}, {8'd252, 8'd144, 8'd66},
        {8'd252, 8'd75,  8'd32},  {8'd237, 8'd28,  8'd41},  {8'd214, 8'd3,   8'd64},
        {8'd183, 8'd3,   8'd101}, {8'd157, 8'd3,   8'd122}, {8'd122, 8'd3,   8'd126},
        {8'd80,  8'd2,   8'd110}, {8'd45,  8'd2,   8'd89},  {8'd19,  8'd2,   8'd70},
        {8'd1,   8'd3,   8'd53},  {8'd1,   8'd3,   8'd37},  {8'd1,   8'd2,   8'd19},
        {8'd0,   8'd0,   8'd0}
    };

    typedef enum int
    {
        TRAFFIC_STEADY,
        TRAFFIC_SENDER_IDLE,
        TRAFFIC_RECEIVER_STALL,
        TRAFFIC_BOTH
    } traffic_t;

    typedef struct
    {
        db_t   level;
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    db_t                  db_value   = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    chan_t                red;
    chan_t                green;
    chan_t                blue;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [AddrWidth-1:0] paddr      = '0;
    logic [DataWidth-1:0] pwdata     = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    // our copy of the register settings
    db_t    floor_cfg = FloorReset;
    logic   gray_cfg  = GrayReset;

    // levels waiting to be sent and pixels waiting to come back
    db_t    level_q[$];
    pixel_t pixel_expect_q[$];
    int     queued_total   = 0;
    int     accepted_total = 0;
    int     mismatch_count = 0;

    // traffic shaping
    int     sender_idle_pct    = 0;
    int     receiver_stall_pct = 0;
    logic   long_hold_armed    = 1'b0;
    int     hold_count         = 0;
    int     stuck_cycles       = 0;
    pixel_t want_pixel;

    decibel_to_heatmap_colour u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .db_value   (db_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // linear blend of two table entries, 8-bit fraction, round half to even
    function automatic chan_t blend_channel(input int unsigned near_val,
                                            input int unsigned far_val,
                                            input int unsigned frac);
        int unsigned sum;
        int unsigned quo;
        sum = (256 - frac) * near_val + frac * far_val;
        quo = sum >> 8;
        if ((sum & 255) > 128 || ((sum & 255) == 128 && (quo & 1) == 1))
            quo++;
        return (quo > 255) ? chan_t'(255) : chan_t'(quo);
    endfunction

    // pixel that one level should turn into under the given settings
    function automatic pixel_t predict_pixel(input db_t level, input db_t floor_reg,
                                             input logic gray);
        db_t         eff_floor;
        longint      mag_floor;
        longint      step;
        int unsigned idx;
        int unsigned frac;
        chan_t       shade;
        pixel_t      pix;
        // floors that are not negative enough act as the shallowest floor
        eff_floor = (floor_reg > FloorMax) ? FloorMax : floor_reg;
        mag_floor = -longint'(eff_floor);
        pix.level = level;
        if (gray)
        begin
            if (level <= eff_floor)
                shade = 8'd0;
            else if (level > 0)
                shade = 8'd255;
            else
            begin
                step  = (-longint'(level)) * GrayScale / mag_floor;
                shade = (step > 254) ? chan_t'(1) : chan_t'(255 - step);
            end
            pix.red   = shade;
            pix.green = shade;
            pix.blue  = shade;
        end
        else if (level >= 0)
        begin
            pix.red   = 8'd255;
            pix.green = 8'd255;
            pix.blue  = 8'd255;
        end
        else
        begin
            // table position with 8 fraction bits
            step = (-longint'(level)) * ColourScale / mag_floor;
            idx  = int'(step >> 8);
            frac = int'(step & 255);
            if (idx >= HeatSteps)
            begin
                pix.red   = 8'd0;
                pix.green = 8'd0;
                pix.blue  = 8'd0;
            end
            else
            begin
                pix.red   = blend_channel(HeatTable[idx][23:16], HeatTable[idx+1][23:16], frac);
                pix.green = blend_channel(HeatTable[idx][15:8],  HeatTable[idx+1][15:8],  frac);
                pix.blue  = blend_channel(HeatTable[idx][7:0],   HeatTable[idx+1][7:0],   frac);
            end
        end
        return pix;
    endfunction

    // random level, mostly spread over the ramp, some near its ends, some anywhere
    function automatic db_t random_level(input db_t floor_reg);
        longint      reach;
        longint      lvl;
        int unsigned pick;
        reach = (floor_reg > FloorMax) ? 256 : -longint'(floor_reg);
        pick  = $urandom_range(99);
        if (pick < 15)
            return db_t'($urandom);
        if (pick < 25)
            lvl = -reach + longint'($urandom_range(6)) - 3;
        else if (pick < 35)
            lvl = longint'($urandom_range(6)) - 3;
        else
            lvl = -longint'($urandom_range(reach + reach / 8));
        if (lvl < -524288)
            lvl = -524288;
        return db_t'(lvl);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MaxReported)
            $display("mismatch: %s", what);
    endtask

    task automatic check_channel(input string name, input db_t level,
                                 input chan_t got, input chan_t want);
        if (got !== want)
            report_mismatch($sformatf("level %0d %s got %0d want %0d",
                                      level, name, got, want));
    endtask

    // register write: setup cycle, access cycle, done at the edge with pready high
    task automatic reg_write(input reg_index_t which, input logic [DataWidth-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (which)
            REG_FLOOR_DB:  floor_cfg = db_t'(data);
            REG_GRAY_MODE: gray_cfg  = data[0];
            default:       ;
        endcase
    endtask

    task automatic set_colour_map(input db_t floor_val, input logic gray);
        reg_write(REG_FLOOR_DB, DataWidth'(floor_val));
        reg_write(REG_GRAY_MODE, DataWidth'(gray));
    endtask

    task automatic set_traffic(input traffic_t mode);
        case (mode)
            TRAFFIC_STEADY:
            begin
                sender_idle_pct    <= 0;
                receiver_stall_pct <= 0;
            end
            TRAFFIC_SENDER_IDLE:
            begin
                sender_idle_pct    <= 77;
                receiver_stall_pct <= 0;
            end
            TRAFFIC_RECEIVER_STALL:
            begin
                sender_idle_pct    <= 0;
                receiver_stall_pct <= 77;
            end
            default:
            begin
                sender_idle_pct    <= 30;
                receiver_stall_pct <= 30;
            end
        endcase
    endtask

    task automatic queue_level(input db_t level);
        level_q.push_back(level);
        queued_total++;
    endtask

    // every request sent and every pixel back, then let the pipeline settle
    task automatic wait_for_drain();
        while (accepted_total != queued_total || pixel_expect_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // stimulus sequence
    initial
    begin
        db_t  floor_pick;
        logic gray_pick;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // floor of exactly 18 steps: position equals the level, so the
        // fraction is exposed directly, including the half-way tie
        set_colour_map(-20'sd4608, 1'b0);
        queue_level(20'sd524287);
        queue_level(20'sd0);
        queue_level(-20'sd1);
        queue_level(-20'sd128);
        queue_level(-20'sd384);
        queue_level(-20'sd256);
        queue_level(-20'sd4352);
        queue_level(-20'sd4607);
        queue_level(-20'sd4608);
        queue_level(-20'sd4609);
        queue_level(-20'sd524288);
        wait_for_drain();

        // gray ramp at the default floor: floor itself, just above, positive
        // levels that saturate, 0 dB, just below it, mid-ramp, far below the floor
        set_colour_map(FloorReset, 1'b1);
        queue_level(FloorReset);
        queue_level(FloorReset + 20'sd1);
        queue_level(20'sd1);
        queue_level(20'sd524287);
        queue_level(20'sd0);
        queue_level(-20'sd1);
        queue_level(-20'sd524288);
        queue_level(-20'sd23040);
        wait_for_drain();

        // zero floor acts as the shallowest floor, both maps
        set_colour_map(20'sd0, 1'b1);
        queue_level(-20'sd256);
        queue_level(-20'sd255);
        queue_level(-20'sd1);
        wait_for_drain();
        reg_write(REG_GRAY_MODE, DataWidth'(1'b0));
        queue_level(-20'sd128);
        queue_level(-20'sd256);
        queue_level(-20'sd1);
        wait_for_drain();

        // random phases over floor extremes, default, random and clamped floors
        for (int p = 0; p < RandomPhases; p++)
        begin
            case (p % 5)
                0: floor_pick = FloorMax;
                1: floor_pick = -20'sd524288;
                2: floor_pick = FloorReset;
                3: floor_pick = db_t'(-longint'($urandom_range(524288, 256)));
                default:
                begin
                    if (p < 5)
                        floor_pick = db_t'(-longint'($urandom_range(524288, 256)));
                    else if ($urandom_range(1) == 1)
                        floor_pick = db_t'($urandom_range(524287));
                    else
                        floor_pick = db_t'(-longint'($urandom_range(255, 1)));
                end
            endcase
            gray_pick = p[0];
            set_colour_map(floor_pick, gray_pick);
            set_traffic(traffic_t'(p % 4));
            // one steady phase holds the output off long enough to back up the input
            if (p == 4)
                long_hold_armed <= 1'b1;
            for (int n = 0; n < LevelsPerRun; n++)
                queue_level(random_level(floor_cfg));
            wait_for_drain();
        end

        if (mismatch_count == 0 && pixel_expect_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // request driver: predicts each accepted level, then offers the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pixel_expect_q.push_back(predict_pixel(db_value, floor_cfg, gray_cfg));
                accepted_total++;
            end
            // a stalled request keeps its level
            if (!(in_valid && in_stall))
            begin
                if (level_q.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    db_value <= level_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor and output stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pixel_expect_q.size() == 0)
                begin
                    report_mismatch($sformatf("pixel %0d/%0d/%0d with no level waiting",
                                              red, green, blue));
                end
                else
                begin
                    want_pixel = pixel_expect_q.pop_front();
                    check_channel("red",   want_pixel.level, red,   want_pixel.red);
                    check_channel("green", want_pixel.level, green, want_pixel.green);
                    check_channel("blue",  want_pixel.level, blue,  want_pixel.blue);
                end
            end
            // long hold-off, counted here, then back to random stalls
            if (long_hold_armed && hold_count < LongHold)
            begin
                out_stall <= 1'b1;
                hold_count++;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    // watchdog: too long with nothing moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WatchdogLimit)
        begin
            $display("timeout: no request or pixel moved for %0d cycles", stuck_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
